// ----- design/sv39_page_table_walker_defines.svh -----
// Assertion macros for the Sv39 page-table walker checker.
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

// Clocked implication check, switched off while reset is held.
`define SV39_PTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Same, with the consequence in the cycle after the antecedent.
`define SV39_PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sv39_ptw_pkg.sv -----
// Shared constants and types of the Sv39 page-table walker.
`default_nettype none
package sv39_ptw_pkg;

    localparam int TABLE_PAGES      = 256;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int STORE_DEPTH      = TABLE_PAGES * ENTRIES_PER_PAGE;

    localparam int PPN_W   = 44;
    localparam int VA_W    = 39;
    localparam int IDX_W   = 17;
    localparam int PTE_W   = 64;
    localparam int PA_W    = 56;
    localparam int VPN_W   = 9;
    localparam int OFS_W   = 12;
    localparam int CFG_W   = 44;
    localparam int PAGE_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W  = PAGE_W + VPN_W;

    // PTE flag bits
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_X = 3;
    localparam int PTE_PPN_LO = 10;

    // configuration register indexes
    localparam logic CFG_ROOT = 1'b0;
    localparam logic CFG_BASE = 1'b1;

    // input commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_XLATED  = 2'd0,
        ST_FAULT   = 2'd1,
        ST_WRITTEN = 2'd2
    } t_status;

    // result of the page-range unit
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } t_map;

endpackage
`default_nettype wire

// ----- design/sv39_ptw_store.sv -----
// Table-entry store: one write port, one registered read port.
`default_nettype none
module sv39_ptw_store (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [sv39_ptw_pkg::ADDR_W-1:0]  i_waddr,
    input  wire logic [sv39_ptw_pkg::PTE_W-1:0]   i_wdata,
    input  wire logic                             i_re,
    input  wire logic [sv39_ptw_pkg::ADDR_W-1:0]  i_raddr,
    output logic      [sv39_ptw_pkg::PTE_W-1:0]   o_rdata
);

    logic [sv39_ptw_pkg::PTE_W-1:0] r_mem [sv39_ptw_pkg::STORE_DEPTH];
    logic [sv39_ptw_pkg::PTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/sv39_ptw_pmap.sv -----
// Shared page-range unit: table page to store position, with range check.
`default_nettype none
module sv39_ptw_pmap (
    input  wire logic [sv39_ptw_pkg::PPN_W-1:0] i_ppn,
    input  wire logic [sv39_ptw_pkg::PPN_W-1:0] i_base,
    input  wire logic [sv39_ptw_pkg::VPN_W-1:0] i_vpn,
    output sv39_ptw_pkg::t_map                  o_map
);

    logic [sv39_ptw_pkg::PPN_W:0] rel;

    // one subtract; the borrow bit flags a page below the base
    assign rel = {1'b0, i_ppn} - {1'b0, i_base};

    always_comb begin
        o_map.hit  = !rel[sv39_ptw_pkg::PPN_W] &&
                     (rel < (sv39_ptw_pkg::PPN_W+1)'(sv39_ptw_pkg::TABLE_PAGES));
        o_map.addr = {rel[sv39_ptw_pkg::PAGE_W-1:0], i_vpn};
    end

endmodule
`default_nettype wire

// ----- design/sv39_page_table_walker.sv -----
// Top level of the Sv39 page-table walker: sequencer, registers, results.
`default_nettype none
// Sv39 walker over a local store of 64-bit table entries
// (TABLE_PAGES pages of 512 entries, physical pages store_base_page up).
// Raise i_start with i_cmd and the payload while o_busy is low; the beat is
// taken on that edge. A write (cmd 0) stores i_entry_value at i_entry_index;
// o_busy stays low, so writes may be issued every cycle. A translate (cmd 1)
// walks levels 2, 1, 0; each level goes through S_MAP, which range-checks the
// table page in the shared page-range unit and issues the read, and then
// S_CHECK, which examines the store's registered read data. o_busy stays
// high for the whole walk. A table page outside the store faults in S_MAP;
// an invalid entry, a leaf above level 0 or a non-leaf at level 0 faults in
// S_CHECK. Every item gives exactly one result, shown on o_status,
// o_phys_addr and o_final_entry for the single cycle in which o_done is high,
// the cycle after the item finishes. The receiver cannot stall: a result
// not taken in that cycle is gone. Store entries are undefined until
// written; there is no clearing pass, and a walk through unwritten entries
// returns unspecified values. Configuration writes (index 0 root page
// number, index 1 store base page) are taken at any edge with i_cfg_we
// high, and must only be made while the block is idle.
module sv39_page_table_walker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [sv39_ptw_pkg::CFG_W-1:0]   i_cfg_data,
    // command side
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic                             i_cmd,
    input  wire logic [sv39_ptw_pkg::VA_W-1:0]    i_virt_addr,
    input  wire logic [sv39_ptw_pkg::IDX_W-1:0]   i_entry_index,
    input  wire logic [sv39_ptw_pkg::PTE_W-1:0]   i_entry_value,
    // result side
    output logic                                  o_done,
    output logic      [1:0]                       o_status,
    output logic      [sv39_ptw_pkg::PA_W-1:0]    o_phys_addr,
    output logic      [sv39_ptw_pkg::PTE_W-1:0]   o_final_entry
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAP   = 3'b010,   // range-check table page, issue read
        S_CHECK = 3'b100    // examine the entry just read
    } t_state;

    t_state r_state, n_state;
    logic [1:0]                       r_level, n_level;
    logic [sv39_ptw_pkg::VA_W-1:0]    r_va, n_va;
    logic [sv39_ptw_pkg::PPN_W-1:0]   r_ppn, n_ppn;
    logic [sv39_ptw_pkg::PPN_W-1:0]   r_root, n_root;
    logic [sv39_ptw_pkg::PPN_W-1:0]   r_base, n_base;
    logic                             r_done, n_done;
    sv39_ptw_pkg::t_status            r_status, n_status;
    logic [sv39_ptw_pkg::PA_W-1:0]    r_pa, n_pa;
    logic [sv39_ptw_pkg::PTE_W-1:0]   r_fe, n_fe;

    logic [sv39_ptw_pkg::VPN_W-1:0]   vpn;
    sv39_ptw_pkg::t_map               map;
    logic [sv39_ptw_pkg::PTE_W-1:0]   pte;
    logic                             pte_leaf;
    logic                             accept;
    logic                             mem_we;
    logic [sv39_ptw_pkg::ADDR_W-1:0]  mem_waddr;
    logic                             mem_re;

    assign accept = i_start && (r_state == S_IDLE);

    // VPN slice for the level in hand
    always_comb begin
        case (r_level)
            2'd2:    vpn = r_va[38:30];
            2'd1:    vpn = r_va[29:21];
            default: vpn = r_va[20:12];
        endcase
    end

    sv39_ptw_pmap u_pmap (
        .i_ppn  (r_ppn),
        .i_base (r_base),
        .i_vpn  (vpn),
        .o_map  (map)
    );

    // writes beyond the store are dropped but still acknowledged
    assign mem_we    = accept && (i_cmd == sv39_ptw_pkg::CMD_WRITE) &&
                       ({15'd0, i_entry_index} < 32'(sv39_ptw_pkg::STORE_DEPTH));
    assign mem_waddr = sv39_ptw_pkg::ADDR_W'(i_entry_index);
    assign mem_re    = (r_state == S_MAP) && map.hit;

    sv39_ptw_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_entry_value),
        .i_re    (mem_re),
        .i_raddr (map.addr),
        .o_rdata (pte)
    );

    assign pte_leaf = pte[sv39_ptw_pkg::PTE_R] || pte[sv39_ptw_pkg::PTE_W_BIT] ||
                      pte[sv39_ptw_pkg::PTE_X];

    always_comb begin
        n_state  = r_state;
        n_level  = r_level;
        n_va     = r_va;
        n_ppn    = r_ppn;
        n_root   = r_root;
        n_base   = r_base;
        n_done   = 1'b0;
        n_status = r_status;
        n_pa     = r_pa;
        n_fe     = r_fe;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sv39_ptw_pkg::CFG_ROOT: n_root = i_cfg_data;
                sv39_ptw_pkg::CFG_BASE: n_base = i_cfg_data;
                default:                n_base = r_base;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == sv39_ptw_pkg::CMD_WRITE) begin
                        n_done   = 1'b1;
                        n_status = sv39_ptw_pkg::ST_WRITTEN;
                        n_pa     = '0;
                        n_fe     = '0;
                    end else begin
                        n_va    = i_virt_addr;
                        n_ppn   = r_root;
                        n_level = 2'd2;
                        n_state = S_MAP;
                    end
                end
            end
            S_MAP: begin
                if (map.hit) begin
                    n_state = S_CHECK;
                end else begin
                    // table page outside the store
                    n_done   = 1'b1;
                    n_status = sv39_ptw_pkg::ST_FAULT;
                    n_pa     = '0;
                    n_fe     = '0;
                    n_state  = S_IDLE;
                end
            end
            S_CHECK: begin
                n_pa = '0;
                n_fe = '0;
                if (r_level != 2'd0) begin
                    // superpages refused: leaf or invalid above level 0 faults
                    if (!pte[sv39_ptw_pkg::PTE_V] || pte_leaf) begin
                        n_done   = 1'b1;
                        n_status = sv39_ptw_pkg::ST_FAULT;
                        n_state  = S_IDLE;
                    end else begin
                        n_ppn   = pte[53:10];
                        n_level = r_level - 2'd1;
                        n_state = S_MAP;
                    end
                end else begin
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    n_status = sv39_ptw_pkg::ST_FAULT;
                    if (pte[sv39_ptw_pkg::PTE_V]) begin
                        n_fe = pte;
                        if (pte_leaf) begin
                            n_status = sv39_ptw_pkg::ST_XLATED;
                            n_pa     = {pte[53:10], r_va[11:0]};
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_level <= 2'd0;
            r_root  <= '0;
            r_base  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_root  <= n_root;
            r_base  <= n_base;
            r_done  <= n_done;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_va     <= n_va;
        r_ppn    <= n_ppn;
        r_status <= n_status;
        r_pa     <= n_pa;
        r_fe     <= n_fe;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_phys_addr   = r_pa;
    assign o_final_entry = r_fe;

endmodule
`default_nettype wire

// ----- design/sv39_ptw_checker.sv -----
// Port-level checks of the Sv39 page-table walker, bound to the top level.
`default_nettype none
`include "sv39_page_table_walker_defines.svh"
module sv39_ptw_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             o_busy,
    input  wire logic                             i_cmd,
    input  wire logic                             o_done,
    input  wire logic [1:0]                       o_status,
    input  wire logic [sv39_ptw_pkg::PA_W-1:0]    o_phys_addr,
    input  wire logic [sv39_ptw_pkg::PTE_W-1:0]   o_final_entry
);

    logic wr_beat, xl_beat;
    assign wr_beat = i_start && !o_busy && (i_cmd == sv39_ptw_pkg::CMD_WRITE);
    assign xl_beat = i_start && !o_busy && (i_cmd == sv39_ptw_pkg::CMD_XLATE);

    // a write is acknowledged in the very next cycle
    `SV39_PTW_ASSERT_NEXT(a_write_ack, i_clk, i_rst_n, wr_beat, o_done && (o_status == sv39_ptw_pkg::ST_WRITTEN), "write beat not acknowledged next cycle")

    // a translate leaves the block busy, with no result yet, in the next cycle
    `SV39_PTW_ASSERT_NEXT(a_xlate_busy, i_clk, i_rst_n, xl_beat, o_busy && !o_done, "translate beat did not start a walk")

    // no physical address unless translated
    `SV39_PTW_ASSERT_IMP(a_pa_zero, i_clk, i_rst_n, o_done && (o_status != sv39_ptw_pkg::ST_XLATED), o_phys_addr == '0, "address given without translation")

    // write results carry no entry
    `SV39_PTW_ASSERT_IMP(a_wr_clean, i_clk, i_rst_n, o_done && (o_status == sv39_ptw_pkg::ST_WRITTEN), o_final_entry == '0, "write result carries an entry")

endmodule

bind sv39_page_table_walker sv39_ptw_checker u_sv39_ptw_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the Sv39 page-table walker: random table builds, walks and faults.
`timescale 1ns / 1ps

module tb;
    import sv39_ptw_pkg::*;

    // Run limit in clock cycles. Each beat waits at most one random hold-off
    // and one full walk with its result, which leaves ample headroom.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles to let pass once nothing is outstanding (full walk plus result).
    localparam int SETTLE_CYCLES = 10;
    // Random beats after the directed part.
    localparam int RANDOM_BEATS  = 500;
    // Beats between changes of the walker registers.
    localparam int PHASE_BEATS   = 70;
    // Beats at the tail of the run sent back to back.
    localparam int QUIET_BEATS   = 90;
    // Marks a table build with no broken level.
    localparam int INTACT        = -1;

    localparam logic [PPN_W-1:0] PPN_MAX = '1;

    // One expected result beat.
    typedef struct {
        t_status          status;
        logic [PA_W-1:0]  pa;
        logic [PTE_W-1:0] fe;
    } t_walk_result;

    // Mirror of the walker: its registers, its entry store and the result
    // beats still owed by the block.
    class walk_tracker;
        logic [PPN_W-1:0] root_ppn = '0;
        logic [PPN_W-1:0] base_ppn = '0;
        logic [PTE_W-1:0] entries [STORE_DEPTH];
        bit               filled  [STORE_DEPTH];
        t_walk_result     due_results [$];
        int unsigned      mismatches = 0;

        function void write_reg(input logic idx, input logic [PPN_W-1:0] data);
            if (idx == CFG_ROOT)
                root_ppn = data;
            else
                base_ppn = data;
        endfunction

        // Physical page to store page; 0 if the page lies outside the store.
        function bit page_in_store(input logic [PPN_W-1:0] ppn, output int unsigned page);
            logic [PPN_W:0] rel;
            page = 0;
            if (ppn < base_ppn)
                return 0;
            rel = {1'b0, ppn} - {1'b0, base_ppn};
            if (rel >= TABLE_PAGES)
                return 0;
            page = 32'(rel);
            return 1;
        endfunction

        function bit root_page(output int unsigned page);
            return page_in_store(root_ppn, page);
        endfunction

        // Three-level walk. Also reports the first store entry that the walk
        // would read without it ever having been written (a hole).
        function void predict_walk(input logic [VA_W-1:0] va, output t_status st,
                                   output logic [PA_W-1:0] pa, output logic [PTE_W-1:0] fe,
                                   output bit hole, output int unsigned hole_pos,
                                   output int hole_level);
            int unsigned      page;
            int unsigned      pos;
            logic [PTE_W-1:0] pte;
            st = ST_FAULT;
            pa = '0;
            fe = '0;
            hole = 0;
            hole_pos = 0;
            hole_level = 0;
            pte = '0;
            if (!page_in_store(root_ppn, page))
                return;
            for (int lvl = 2; lvl >= 0; lvl--) begin
                pos = page * ENTRIES_PER_PAGE + va[OFS_W + VPN_W*lvl +: VPN_W];
                if (!filled[pos]) begin
                    hole = 1;
                    hole_pos = pos;
                    hole_level = lvl;
                    return;
                end
                pte = entries[pos];
                if (!pte[PTE_V])
                    return;
                if (lvl == 0)
                    break;
                // superpages refused
                if (pte[PTE_X:PTE_R] != 3'b000)
                    return;
                if (!page_in_store(pte[PTE_PPN_LO +: PPN_W], page))
                    return;
            end
            fe = pte;
            if (pte[PTE_X:PTE_R] != 3'b000) begin
                st = ST_XLATED;
                pa = {pte[PTE_PPN_LO +: PPN_W], va[OFS_W-1:0]};
            end
        endfunction

        function bit find_hole(input logic [VA_W-1:0] va, output int unsigned pos,
                               output int lvl);
            t_status          st;
            logic [PA_W-1:0]  pa;
            logic [PTE_W-1:0] fe;
            bit               hole;
            predict_walk(va, st, pa, fe, hole, pos, lvl);
            return hole;
        endfunction

        // Accepted command beat: update the store and queue the result owed.
        function void take_beat(input logic cmd, input logic [VA_W-1:0] va,
                                input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] val);
            t_walk_result r;
            bit           hole;
            int unsigned  hp;
            int           hl;
            if (cmd == CMD_WRITE) begin
                entries[idx] = val;
                filled[idx] = 1;
                r.status = ST_WRITTEN;
                r.pa = '0;
                r.fe = '0;
            end else begin
                predict_walk(va, r.status, r.pa, r.fe, hole, hp, hl);
            end
            due_results.push_back(r);
        endfunction

        // Result beat from the block, against the oldest owed result.
        function void check_beat(input logic [1:0] st, input logic [PA_W-1:0] pa,
                                 input logic [PTE_W-1:0] fe);
            t_walk_result r;
            if (due_results.size() == 0) begin
                $display("%0t: result beat with nothing owed: status %0d pa %h entry %h",
                         $time, st, pa, fe);
                mismatches++;
                return;
            end
            r = due_results.pop_front();
            if (st !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                mismatches++;
            end
            if (pa !== r.pa) begin
                $display("%0t: phys_addr expected %h actual %h", $time, r.pa, pa);
                mismatches++;
            end
            if (fe !== r.fe) begin
                $display("%0t: final_entry expected %h actual %h", $time, r.fe, fe);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_start;
    logic               o_busy;
    logic               i_cmd;
    logic [VA_W-1:0]    i_virt_addr;
    logic [IDX_W-1:0]   i_entry_index;
    logic [PTE_W-1:0]   i_entry_value;
    logic               o_done;
    logic [1:0]         o_status;
    logic [PA_W-1:0]    o_phys_addr;
    logic [PTE_W-1:0]   o_final_entry;

    walk_tracker trk;
    int unsigned beats_sent;
    int unsigned cycles;
    bit          quiet;

    sv39_page_table_walker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cmd         (i_cmd),
        .i_virt_addr   (i_virt_addr),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_phys_addr   (o_phys_addr),
        .o_final_entry (o_final_entry)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: a hung walk or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sv39_page_table_walker: mismatch");
            $finish;
        end
    end

    // Result side. The block cannot be stalled, so every strobed cycle is one
    // result beat; an X strobe is treated as a beat and so gets flagged.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0)
            trk.check_beat(o_status, o_phys_addr, o_final_entry);
    end

    // ---------------------------------------------------------------------
    // Entry generators
    // ---------------------------------------------------------------------

    // Random store page whose physical page number is representable.
    function automatic int unsigned pick_page();
        int unsigned k;
        k = $urandom_range(0, TABLE_PAGES - 1);
        if ({1'b0, trk.base_ppn} + k > {1'b0, PPN_MAX})
            k = 0;
        return k;
    endfunction

    function automatic logic [PPN_W-1:0] page_ppn(input int unsigned k);
        return PPN_W'(trk.base_ppn + k);
    endfunction

    // Page number just outside the store (either end, wrapping) or anywhere.
    function automatic logic [PPN_W-1:0] stray_ppn(input logic [PPN_W-1:0] base);
        case ($urandom_range(0, 2))
            0:       return base - 1'b1;
            1:       return base + PPN_W'(TABLE_PAGES);
            default: return PPN_W'({$urandom, $urandom});
        endcase
    endfunction

    // Pointer to a next-level table: V set, R/W/X clear, the rest random.
    function automatic logic [PTE_W-1:0] table_pte(input logic [PPN_W-1:0] ppn);
        return {10'($urandom), ppn, 6'($urandom), 3'b000, 1'b1};
    endfunction

    function automatic logic [PTE_W-1:0] leaf_pte(input logic [PPN_W-1:0] ppn);
        return {10'($urandom), ppn, 6'($urandom), 3'($urandom_range(1, 7)), 1'b1};
    endfunction

    // Entry that breaks a walk: invalid, superpage, pointer out of the
    // store (a non-leaf at level 0), or plain noise.
    function automatic logic [PTE_W-1:0] odd_pte();
        case ($urandom_range(0, 3))
            0:       return {63'({$urandom, $urandom}), 1'b0};
            1:       return leaf_pte(PPN_W'({$urandom, $urandom}));
            2:       return table_pte(stray_ppn(trk.base_ppn));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [PTE_W-1:0] fill_entry(input int lvl);
        if ($urandom_range(0, 3) == 0)
            return odd_pte();
        if (lvl == 0)
            return leaf_pte(PPN_W'({$urandom, $urandom}));
        return table_pte(page_ppn(pick_page()));
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One command beat: driven on the falling edge, held until a rising edge
    // sees o_busy low. Unused payload fields carry noise.
    task automatic send_beat(input logic cmd, input logic [VA_W-1:0] va,
                             input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] val);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_cmd         <= cmd;
        i_virt_addr   <= va;
        i_entry_index <= idx;
        i_entry_value <= val;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        trk.take_beat(cmd, va, idx, val);
        beats_sent++;
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk) i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 18));
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] val);
        maybe_pause();
        send_beat(CMD_WRITE, VA_W'({$urandom, $urandom}), idx, val);
    endtask

    // Translate, first plugging any never-written entry on the walk so the
    // block is never asked to read an undefined one.
    task automatic send_xlate(input logic [VA_W-1:0] va);
        int unsigned pos;
        int          lvl;
        while (trk.find_hole(va, pos, lvl))
            send_write(IDX_W'(pos), fill_entry(lvl));
        maybe_pause();
        send_beat(CMD_XLATE, va, IDX_W'($urandom), {$urandom, $urandom});
    endtask

    // Wait until every owed result is in, then let the walker settle.
    task automatic drain();
        @(negedge i_clk) i_start <= 1'b0;
        while (trk.outstanding() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_walker(input logic [PPN_W-1:0] root, input logic [PPN_W-1:0] base);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        trk.write_reg(CFG_BASE, base);
        @(negedge i_clk);
        i_cfg_index <= CFG_ROOT;
        i_cfg_data  <= root;
        @(posedge i_clk);
        trk.write_reg(CFG_ROOT, root);
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Fresh random register setting; mostly a root inside the store.
    task automatic pick_settings();
        logic [PPN_W-1:0] base;
        logic [PPN_W-1:0] root;
        int unsigned      k;
        case ($urandom_range(0, 4))
            0:       base = '0;
            1:       base = PPN_W'({$urandom, $urandom});
            2:       base = PPN_MAX - PPN_W'(TABLE_PAGES - 1);
            3:       base = PPN_MAX;
            default: base = PPN_W'($urandom_range(0, 4096));
        endcase
        k = $urandom_range(0, TABLE_PAGES - 1);
        if ({1'b0, base} + k > {1'b0, PPN_MAX})
            k = 0;
        root = base + PPN_W'(k);
        if ($urandom_range(0, 7) == 0)
            root = stray_ppn(base);
        program_walker(root, base);
    endtask

    // Build a three-level path for va, optionally with one level broken,
    // then walk it once or a few times with other page offsets.
    task automatic build_path(input logic [VA_W-1:0] va, input int broken);
        int unsigned k2;
        int unsigned k1;
        int unsigned k0;
        int          extra;
        void'(trk.root_page(k2));
        k1 = pick_page();
        k0 = pick_page();
        send_write(IDX_W'(k2 * ENTRIES_PER_PAGE + va[38:30]),
                   broken == 2 ? odd_pte() : table_pte(page_ppn(k1)));
        send_write(IDX_W'(k1 * ENTRIES_PER_PAGE + va[29:21]),
                   broken == 1 ? odd_pte() : table_pte(page_ppn(k0)));
        send_write(IDX_W'(k0 * ENTRIES_PER_PAGE + va[20:12]),
                   broken == 0 ? odd_pte() : leaf_pte(PPN_W'({$urandom, $urandom})));
        send_xlate(va);
        extra = $urandom_range(0, 2);
        repeat (extra) send_xlate({va[VA_W-1:OFS_W], 12'($urandom)});
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int unsigned      goal;
        int unsigned      phase_start;
        int unsigned      k;
        int unsigned      roll;
        logic [VA_W-1:0]  va;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ROOT;
        i_cfg_data    = '0;
        i_start       = 1'b0;
        i_cmd         = CMD_WRITE;
        i_virt_addr   = '0;
        i_entry_index = '0;
        i_entry_value = '0;
        beats_sent    = 0;
        cycles        = 0;
        quiet         = 0;
        trk           = new();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed part, registers at reset (root page 0, store from page 0).
        // Invalid entry at level 2.
        send_write('0, '0);
        send_xlate('0);
        // Superpage at level 2.
        send_write('0, 64'hFFC0_0000_0000_0003);
        send_xlate('0);
        // Level 2 points to page 1; superpage at level 1.
        send_write('0, table_pte(44'd1));
        send_write(IDX_W'(ENTRIES_PER_PAGE), 64'h0000_0000_0000_0009);
        send_xlate('0);
        // Next table beyond the store.
        send_write(IDX_W'(ENTRIES_PER_PAGE), table_pte(44'd300));
        send_xlate('0);
        // Level-0 entry valid but not a leaf: fault carrying the entry.
        send_write(IDX_W'(ENTRIES_PER_PAGE), table_pte(44'd2));
        send_write(IDX_W'(2 * ENTRIES_PER_PAGE), 64'h003F_FFFF_FFFF_FC01);
        send_xlate('0);
        // Invalid level-0 entry with every other bit set.
        send_write(IDX_W'(2 * ENTRIES_PER_PAGE), 64'hFFFF_FFFF_FFFF_FFFE);
        send_xlate('0);
        // Proper leaf, highest offset.
        send_write(IDX_W'(2 * ENTRIES_PER_PAGE), 64'h0000_0000_0000_040F);
        send_xlate(39'h00_0000_0FFF);
        // All-ones address through pages 0, 3, 255; last entry all ones, so
        // bits 63:54 must stay out of the address.
        send_write(IDX_W'(ENTRIES_PER_PAGE - 1), table_pte(44'd3));
        send_write(IDX_W'(4 * ENTRIES_PER_PAGE - 1), table_pte(44'd255));
        send_write('1, '1);
        send_xlate('1);
        send_write('1, '0);
        send_xlate('1);

        // Root below the store, root just past its top end, store at the very top
        // of the page space.
        program_walker(44'd4, 44'd5);
        send_xlate(VA_W'({$urandom, $urandom}));
        program_walker(44'd5 + PPN_W'(TABLE_PAGES), 44'd5);
        send_xlate(VA_W'({$urandom, $urandom}));
        program_walker(PPN_MAX, PPN_MAX - PPN_W'(TABLE_PAGES - 1));
        send_xlate(VA_W'({$urandom, $urandom}));
        program_walker(PPN_MAX, PPN_MAX);
        send_xlate(VA_W'({$urandom, $urandom}));

        // Random part: mostly well-formed paths with random content, the
        // rest broken paths, stray walks and stray writes. The tail runs
        // with no gaps, so no register change there either.
        program_walker('0, '0);
        goal = beats_sent + RANDOM_BEATS;
        phase_start = beats_sent;
        while (beats_sent < goal) begin
            if (goal - beats_sent < QUIET_BEATS)
                quiet = 1;
            if (!quiet && beats_sent - phase_start >= PHASE_BEATS) begin
                pick_settings();
                phase_start = beats_sent;
            end
            va = VA_W'({$urandom, $urandom});
            roll = $urandom_range(0, 19);
            if (roll <= 13 && trk.root_page(k)) begin
                if (roll <= 10)
                    build_path(va, INTACT);
                else
                    build_path(va, $urandom_range(0, 2));
            end else if (roll <= 16) begin
                send_xlate(va);
            end else begin
                send_write(IDX_W'($urandom), {$urandom, $urandom});
            end
        end

        drain();
        if (trk.mismatches == 0 && trk.outstanding() == 0)
            $display("sv39_page_table_walker: match");
        else
            $display("sv39_page_table_walker: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/sv39_ptw_pkg.sv
design/sv39_ptw_store.sv
design/sv39_ptw_pmap.sv
design/sv39_page_table_walker.sv
design/sv39_ptw_checker.sv
tb/tb.sv
